FILE: hdl/htdp_pkg.sv
package htdp_pkg;

    typedef enum logic [1:0] {
        KIND_LENGTH  = 2'd0,
        KIND_ADDRESS = 2'd1,
        KIND_DATA    = 2'd2,
        KIND_TEXT    = 2'd3
    } t_word_kind;

    typedef enum logic [1:0] {
        TXT_AWAIT_STAR = 2'd0,
        TXT_SKIP_STAR  = 2'd1,
        TXT_SKIP_BLANK = 2'd2,
        TXT_ACTIVE     = 2'd3
    } t_text_phase;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int         POS_W        = 10;
    localparam logic [9:0] POS_IDLE     = 10'h3FF;
    localparam logic [9:0] POS_LEN_HI   = 10'd1;
    localparam logic [9:0] POS_LEN_LO   = 10'd2;
    localparam logic [9:0] POS_ADDR_3   = 10'd3;
    localparam logic [9:0] POS_ADDR_2   = 10'd4;
    localparam logic [9:0] POS_ADDR_1   = 10'd5;
    localparam logic [9:0] POS_ADDR_0   = 10'd6;
    localparam logic [9:0] POS_DATA_MIN = 10'd8;
    localparam logic [17:0] REC_END_BASE = 18'd9;

endpackage

FILE: hdl/hex_and_text_download_parser.sv
// Channel   Direction  Handshake                Payload
// input     in         i_valid / o_stall        i_rx_char
// result    out        o_valid / i_stall        o_word_value, o_slot, o_word_kind,
//                                               o_command_count
// config    in         i_cfg_valid / o_cfg_ready i_cfg_text_mode
//
// One character per cycle while the result channel is not stalled; a result is offered
// after its character is taken (input register, then result register).
// The character update is a single pass of parse logic between the two registers.
// Reset is synchronous, active low; it clears all parser state, char position idle.
// A stalled result holds the result register and backs up into the input register.
module hex_and_text_download_parser #(
    parameter int RING_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_char,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_word_value,
    output logic [4:0]  o_slot,
    output logic [1:0]  o_word_kind,
    output logic [15:0] o_command_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_text_mode
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

    logic                r_text_mode;
    logic                r_in_valid;
    logic [7:0]          r_in_char;
    logic                r_out_valid;
    logic [15:0]         r_word_value;
    logic [SLOT_W-1:0]   r_slot;
    htdp_pkg::t_word_kind r_word_kind;
    logic [15:0]         r_command_count;

    logic [htdp_pkg::POS_W-1:0] r_pos, n_pos;
    logic [htdp_pkg::POS_W-1:0] r_rec_end, n_rec_end;
    logic [15:0]         r_low, n_low;
    logic [15:0]         r_high, n_high;
    logic [SLOT_W-1:0]   r_write_slot, n_write_slot;
    logic [15:0]         r_count, n_count;
    htdp_pkg::t_text_phase r_phase, n_phase;
    logic                r_odd, n_odd;
    logic                r_prev_nul, n_prev_nul;
    logic [7:0]          r_pending, n_pending;

    logic                w_emit;
    logic [15:0]         w_value;
    htdp_pkg::t_word_kind w_kind;
    logic [7:0]          w_digit;
    logic [17:0]         w_end;
    logic                w_eol;
    logic                w_go;
    logic [7:0]          w_ch;
    logic                w_out_free;
    logic                w_advance;
    logic [8:0]          w_slot_ext;

    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_advance   = r_in_valid && w_out_free;
    assign o_stall     = r_in_valid && !w_out_free;
    assign o_cfg_ready = 1'b1;

    assign o_valid         = r_out_valid;
    assign o_word_value    = r_word_value;
    assign w_slot_ext      = 9'(r_slot);
    assign o_slot          = w_slot_ext[4:0];
    assign o_word_kind     = 2'(r_word_kind);
    assign o_command_count = r_command_count;

    always_comb begin
        n_pos        = r_pos;
        n_rec_end    = r_rec_end;
        n_low        = r_low;
        n_high       = r_high;
        n_count      = r_count;
        n_phase      = r_phase;
        n_odd        = r_odd;
        n_prev_nul   = r_prev_nul;
        n_pending    = r_pending;
        w_emit       = 1'b0;
        w_value      = 16'd0;
        w_kind       = htdp_pkg::KIND_LENGTH;
        w_digit      = 8'd0;
        w_end        = 18'd0;
        w_go         = 1'b0;
        w_ch         = r_in_char;
        w_eol        = (r_in_char == htdp_pkg::CH_CR) || (r_in_char == htdp_pkg::CH_LF);

        if (!r_text_mode) begin
            if (r_in_char == htdp_pkg::CH_COLON) begin
                n_pos = '0;
            end else if (r_in_char <= htdp_pkg::CH_NINE) begin
                w_digit = r_in_char - htdp_pkg::CH_ZERO;
            end else begin
                w_digit = r_in_char - htdp_pkg::CH_SEVEN;
            end

            case (n_pos) inside
                htdp_pkg::POS_LEN_HI, htdp_pkg::POS_ADDR_3: begin
                    n_low = {4'd0, w_digit, 4'd0};
                end
                htdp_pkg::POS_LEN_LO: begin
                    n_low     = r_low + 16'(w_digit);
                    w_end     = htdp_pkg::REC_END_BASE + {1'b0, n_low, 1'b0};
                    n_rec_end = (w_end > 18'(htdp_pkg::POS_IDLE)) ? htdp_pkg::POS_IDLE
                                                                   : w_end[9:0];
                    w_emit    = 1'b1;
                    w_value   = n_low;
                    w_kind    = htdp_pkg::KIND_LENGTH;
                end
                htdp_pkg::POS_ADDR_2: begin
                    n_low = {r_low[7:0] + w_digit, 8'd0};
                end
                htdp_pkg::POS_ADDR_1: begin
                    n_low = r_low + {4'd0, w_digit, 4'd0};
                end
                htdp_pkg::POS_ADDR_0: begin
                    n_low   = r_low + 16'(w_digit);
                    w_emit  = 1'b1;
                    w_value = n_low;
                    w_kind  = htdp_pkg::KIND_ADDRESS;
                end
                default: begin
                end
            endcase

            if (n_pos > htdp_pkg::POS_DATA_MIN && n_pos < r_rec_end) begin
                case (n_pos[1:0])
                    2'd1: n_low  = {4'd0, w_digit, 4'd0};
                    2'd2: n_low  = r_low + 16'(w_digit);
                    2'd3: n_high = {4'd0, w_digit, 4'd0};
                    default: begin
                        n_high  = {r_high[7:0] + w_digit, 8'd0};
                        n_low   = r_low + n_high;
                        n_count = r_count + 16'd1;
                        w_emit  = 1'b1;
                        w_value = n_low;
                        w_kind  = htdp_pkg::KIND_DATA;
                    end
                endcase
            end

            if (n_pos != htdp_pkg::POS_IDLE) begin
                n_pos = n_pos + 10'd1;
            end
        end else begin
            if (r_phase == htdp_pkg::TXT_AWAIT_STAR) begin
                if (r_in_char == htdp_pkg::CH_STAR) begin
                    n_phase = htdp_pkg::TXT_SKIP_STAR;
                end
            end else if (r_phase == htdp_pkg::TXT_SKIP_STAR
                         && r_in_char == htdp_pkg::CH_STAR) begin
                n_phase = r_phase;
            end else if ((r_phase == htdp_pkg::TXT_SKIP_STAR
                          || r_phase == htdp_pkg::TXT_SKIP_BLANK) && w_eol) begin
                n_phase = htdp_pkg::TXT_SKIP_BLANK;
            end else begin
                n_phase = htdp_pkg::TXT_ACTIVE;
                w_go    = 1'b1;
            end

            if (w_go && !(w_eol && r_prev_nul)) begin
                w_ch = w_eol ? 8'd0 : r_in_char;
                if (!r_odd) begin
                    n_pending = w_ch;
                end else begin
                    w_emit  = 1'b1;
                    w_value = {r_pending, w_ch};
                    w_kind  = htdp_pkg::KIND_TEXT;
                end
                n_odd      = !r_odd;
                n_prev_nul = (w_ch == 8'd0);
            end
        end

        n_write_slot = r_write_slot;
        if (w_emit) begin
            n_write_slot = (r_write_slot == SLOT_LAST) ? '0 : r_write_slot + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_mode  <= 1'b0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pos        <= htdp_pkg::POS_IDLE;
            r_rec_end    <= '0;
            r_low        <= '0;
            r_high       <= '0;
            r_write_slot <= '0;
            r_count      <= '0;
            r_phase      <= htdp_pkg::TXT_AWAIT_STAR;
            r_odd        <= 1'b0;
            r_prev_nul   <= 1'b0;
            r_pending    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_text_mode <= i_cfg_text_mode;
            end
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_out_free) begin
                r_out_valid <= w_advance && w_emit;
            end
            if (w_advance) begin
                r_pos        <= n_pos;
                r_rec_end    <= n_rec_end;
                r_low        <= n_low;
                r_high       <= n_high;
                r_write_slot <= n_write_slot;
                r_count      <= n_count;
                r_phase      <= n_phase;
                r_odd        <= n_odd;
                r_prev_nul   <= n_prev_nul;
                r_pending    <= n_pending;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_char <= i_rx_char;
        end
        if (w_advance && w_emit) begin
            r_word_value    <= w_value;
            r_slot          <= r_write_slot;
            r_word_kind     <= w_kind;
            r_command_count <= n_count;
        end
    end

endmodule
